>>> rtl/rtts_pkg.sv
// Shared types, widths and command/status structs for the round-trip time statistics block.
package rtts_pkg;

  localparam int TIME_BITS  = 20;
  localparam int COUNT_BITS = 16;
  localparam int OP_BITS    = 2;
  localparam int LOSS_BITS  = 7;
  localparam int LOSS_SCALE = 100;

  localparam int SUM_W  = TIME_BITS + COUNT_BITS;       // running sum
  localparam int SQ_W   = 2 * TIME_BITS;                // one squared time
  localparam int SQS_W  = 2 * TIME_BITS + COUNT_BITS;   // running sum of squares
  localparam int PROD_W = 2 * SUM_W;                    // n*S2 and S1^2
  localparam int ROOT_W = SUM_W;                        // isqrt of PROD_W bits
  localparam int DVD_W  = SUM_W;                        // shared divider dividend
  localparam int LNUM_W = COUNT_BITS + LOSS_BITS;       // 100*(sent-received)
  localparam int STEP_W = $clog2(SUM_W + 1);

  typedef enum logic [OP_BITS-1:0] {
    OP_SENT   = 2'd0,
    OP_REPLY  = 2'd1,
    OP_REPORT = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOSS,
    S_AVG,
    S_MULA,
    S_MULB,
    S_SUB,
    S_SQRT,
    S_SD,
    S_OUT
  } state_e;

  typedef enum logic [1:0] {
    DIV_LOSS,
    DIV_AVG,
    DIV_SD
  } div_sel_e;

  typedef enum logic {
    MUL_A,
    MUL_B
  } mul_sel_e;

  typedef enum logic [2:0] {
    ST_NONE,
    ST_LOSS,
    ST_AVG,
    ST_MULA,
    ST_MULB,
    ST_SD
  } store_e;

  typedef struct packed {
    logic [OP_BITS-1:0]   operation;
    logic [TIME_BITS-1:0] rtt_us;
  } in_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] sent_total;
    logic [COUNT_BITS-1:0] received_total;
    logic [LOSS_BITS-1:0]  loss_percent;
    logic                  rtt_valid;
    logic [TIME_BITS-1:0]  min_rtt_us;
    logic [TIME_BITS-1:0]  avg_rtt_us;
    logic [TIME_BITS-1:0]  max_rtt_us;
    logic [TIME_BITS-1:0]  stddev_rtt_us;
  } out_t;

  typedef struct packed {
    logic     upd_sent;
    logic     upd_reply;
    logic     clear_res;
    logic     div_start;
    div_sel_e div_sel;
    logic     mul_start;
    mul_sel_e mul_sel;
    logic     sqrt_start;
    store_e   store;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic is_sent;
    logic is_reply;
    logic is_report;
    logic rtt_valid;
    logic multi;
    logic div_done;
    logic mul_done;
    logic sqrt_done;
    logic diff_neg;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/round_trip_time_statistics_core.sv
// Top level of the round-trip time statistics block.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one transfer per event.
//   operation sent counts a transmitted packet, reply adds rtt_us to the
//   received count, sum, sum of squares, minimum and maximum; report asks for
//   one result. The unused operation code is dropped with no effect.
// Output channel (out_valid_o / out_stall_i / out_data_o): one transfer per
//   report, from an output register; it holds its payload while stalled.
// Sent and reply events update the statistics when taken and do not stall the
//   input. A report runs on the sequencer: shared restoring divider (used for
//   loss, mean and deviation), shift-add multiplier (n*S2, then S1^2) and a
//   bit-serial square root. With no replies only the loss is computed, with
//   one the mean as well, with two or more also the deviation. The input
//   stalls for the whole report, and a new event is taken in the cycle after
//   the result enters the output register, even while it still waits on a
//   stalled receiver; a finished report waits only if the previous result is
//   still held.
// Reset clears the counters and sums, sets the minimum to all ones and the
//   maximum to zero, and empties the output register.
module round_trip_time_statistics_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  rtts_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output rtts_pkg::out_t  out_data_o
);
  import rtts_pkg::*;

  cmd_t cmd;   // sequencer commands to the datapath
  sts_t sts;   // datapath status back to the sequencer

  rtts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  rtts_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

>>> rtl/rtts_div.sv
// Restoring divider, one quotient bit per cycle.
module rtts_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [rtts_pkg::DVD_W-1:0]      dividend_i,
  input  logic [rtts_pkg::COUNT_BITS-1:0] divisor_i,
  output logic                            done_o,
  output logic [rtts_pkg::DVD_W-1:0]      quot_o
);
  import rtts_pkg::*;

  logic [DVD_W-1:0]      quo_q, quo_d;
  logic [COUNT_BITS-1:0] rem_q, rem_d;
  logic [COUNT_BITS-1:0] dvs_q, dvs_d;
  logic [STEP_W-1:0]     cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [COUNT_BITS:0]   shifted;
  logic [COUNT_BITS:0]   trial;
  logic                  fits;

  always_comb begin
    shifted = {rem_q, quo_q[DVD_W-1]};
    trial   = shifted - {1'b0, dvs_q};
    fits    = (shifted >= {1'b0, dvs_q});
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = STEP_W'(DVD_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[DVD_W-2:0], fits};
      rem_d = fits ? trial[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
      cnt_d = cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

>>> rtl/rtts_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
module rtts_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rtts_pkg::PROD_W-1:0]  radicand_i,
  output logic                         done_o,
  output logic [rtts_pkg::ROOT_W-1:0]  root_o
);
  import rtts_pkg::*;

  logic [PROD_W-1:0]   rad_q, rad_d;
  logic [ROOT_W-1:0]   root_q, root_d;
  logic [ROOT_W+1:0]   rem_q, rem_d;
  logic [STEP_W-1:0]   cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [ROOT_W+3:0]   rem_sh;
  logic [ROOT_W+3:0]   trial;
  logic [ROOT_W+3:0]   rem_sub;
  logic                fits;

  always_comb begin
    rem_sh  = {rem_q, rad_q[PROD_W-1 -: 2]};
    trial   = {2'b00, root_q, 2'b01};
    rem_sub = rem_sh - trial;
    fits    = (rem_sh >= trial);
    rad_d   = rad_q;
    root_d  = root_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      rad_d  = radicand_i;
      root_d = '0;
      rem_d  = '0;
      cnt_d  = STEP_W'(ROOT_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d  = {rad_q[PROD_W-3:0], 2'b00};
      root_d = {root_q[ROOT_W-2:0], fits};
      rem_d  = fits ? rem_sub[ROOT_W+1:0] : rem_sh[ROOT_W+1:0];
      cnt_d  = cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    root_q <= root_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

>>> rtl/rtts_datapath.sv
// Statistics registers, shift-add multiplier, shared divider, square root and output register.
module rtts_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rtts_pkg::in_t   in_data_i,
  input  logic            out_stall_i,
  input  rtts_pkg::cmd_t  cmd_i,
  output rtts_pkg::sts_t  sts_o,
  output logic            out_valid_o,
  output rtts_pkg::out_t  out_data_o
);
  import rtts_pkg::*;

  // running statistics
  logic [COUNT_BITS-1:0] sent_q, sent_d;
  logic [COUNT_BITS-1:0] recv_q, recv_d;
  logic [SUM_W-1:0]      sum_q, sum_d;
  logic [SQS_W-1:0]      sqs_q, sqs_d;
  logic [TIME_BITS-1:0]  min_q, min_d;
  logic [TIME_BITS-1:0]  max_q, max_d;
  logic [SQ_W-1:0]       rtt_sq;

  // report scratch
  logic [PROD_W-1:0]     a_q, b_q;
  logic [PROD_W:0]       diff_w;
  logic [LOSS_BITS-1:0]  loss_q;
  logic [TIME_BITS-1:0]  avg_q, sd_q;
  logic [COUNT_BITS-1:0] cnt_diff;
  logic [LNUM_W-1:0]     lnum;
  logic                  loss_zero;
  logic                  rtt_valid;

  // multiplier
  logic [PROD_W-1:0]     mul_acc_q, mul_acc_d;
  logic [PROD_W-1:0]     mul_mc_q, mul_mc_d;
  logic [SUM_W-1:0]      mul_mp_q, mul_mp_d;
  logic [STEP_W-1:0]     mul_cnt_q, mul_cnt_d;
  logic                  mul_busy_q, mul_busy_d;
  logic                  mul_done_q, mul_done_d;

  // divider and root
  logic [DVD_W-1:0]      div_dvd;
  logic [COUNT_BITS-1:0] div_dvs;
  logic [DVD_W-1:0]      div_quot;
  logic                  div_done;
  logic [ROOT_W-1:0]     root;
  logic                  sqrt_done;

  // output register
  logic                  out_valid_q, out_valid_d;
  out_t                  out_q;

  assign rtt_sq = SQ_W'(in_data_i.rtt_us) * SQ_W'(in_data_i.rtt_us);

  always_comb begin
    sent_d = sent_q;
    recv_d = recv_q;
    sum_d  = sum_q;
    sqs_d  = sqs_q;
    min_d  = min_q;
    max_d  = max_q;
    if (cmd_i.upd_sent && (sent_q != '1)) begin
      sent_d = sent_q + COUNT_BITS'(1);
    end
    if (cmd_i.upd_reply) begin
      // a full count freezes the sums so mean and deviation stay consistent
      if (recv_q != '1) begin
        recv_d = recv_q + COUNT_BITS'(1);
        sum_d  = sum_q + SUM_W'(in_data_i.rtt_us);
        sqs_d  = sqs_q + SQS_W'(rtt_sq);
      end
      if (in_data_i.rtt_us < min_q) min_d = in_data_i.rtt_us;
      if (in_data_i.rtt_us > max_q) max_d = in_data_i.rtt_us;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_q <= '0;
      recv_q <= '0;
      sum_q  <= '0;
      sqs_q  <= '0;
      min_q  <= '1;
      max_q  <= '0;
    end else begin
      sent_q <= sent_d;
      recv_q <= recv_d;
      sum_q  <= sum_d;
      sqs_q  <= sqs_d;
      min_q  <= min_d;
      max_q  <= max_d;
    end
  end

  // loss numerator; discarded when nothing is lost or nothing was sent
  assign cnt_diff  = sent_q - recv_q;
  assign lnum      = LNUM_W'(cnt_diff) * LNUM_W'(LOSS_SCALE);
  assign loss_zero = (recv_q >= sent_q);
  assign rtt_valid = (recv_q != '0);
  assign diff_w    = {1'b0, a_q} - {1'b0, b_q};

  always_comb begin
    case (cmd_i.div_sel)
      DIV_LOSS: begin
        div_dvd = DVD_W'(lnum);
        div_dvs = sent_q;
      end
      DIV_AVG: begin
        div_dvd = sum_q;
        div_dvs = recv_q;
      end
      DIV_SD: begin
        div_dvd = DVD_W'(root);
        div_dvs = recv_q;
      end
      default: begin
        div_dvd = '0;
        div_dvs = recv_q;
      end
    endcase
  end

  rtts_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  rtts_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.sqrt_start),
    .radicand_i (diff_w[PROD_W-1:0]),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  // shift-add multiplier, one multiplier bit per cycle
  always_comb begin
    mul_acc_d  = mul_acc_q;
    mul_mc_d   = mul_mc_q;
    mul_mp_d   = mul_mp_q;
    mul_cnt_d  = mul_cnt_q;
    mul_busy_d = mul_busy_q;
    mul_done_d = 1'b0;
    if (cmd_i.mul_start) begin
      mul_acc_d  = '0;
      mul_busy_d = 1'b1;
      if (cmd_i.mul_sel == MUL_A) begin
        mul_mc_d  = PROD_W'(sqs_q);
        mul_mp_d  = SUM_W'(recv_q);
        mul_cnt_d = STEP_W'(COUNT_BITS);
      end else begin
        mul_mc_d  = PROD_W'(sum_q);
        mul_mp_d  = sum_q;
        mul_cnt_d = STEP_W'(SUM_W);
      end
    end else if (mul_busy_q) begin
      mul_acc_d = mul_acc_q + (mul_mp_q[0] ? mul_mc_q : '0);
      mul_mc_d  = {mul_mc_q[PROD_W-2:0], 1'b0};
      mul_mp_d  = {1'b0, mul_mp_q[SUM_W-1:1]};
      mul_cnt_d = mul_cnt_q - STEP_W'(1);
      if (mul_cnt_q == STEP_W'(1)) begin
        mul_busy_d = 1'b0;
        mul_done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_cnt_q  <= '0;
      mul_busy_q <= 1'b0;
      mul_done_q <= 1'b0;
    end else begin
      mul_cnt_q  <= mul_cnt_d;
      mul_busy_q <= mul_busy_d;
      mul_done_q <= mul_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_acc_q <= mul_acc_d;
    mul_mc_q  <= mul_mc_d;
    mul_mp_q  <= mul_mp_d;
  end

  // report results
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_res) begin
      loss_q <= '0;
      avg_q  <= '0;
      sd_q   <= '0;
    end else begin
      case (cmd_i.store)
        ST_LOSS: loss_q <= loss_zero ? '0 : div_quot[LOSS_BITS-1:0];
        ST_AVG:  avg_q  <= div_quot[TIME_BITS-1:0];
        ST_MULA: a_q    <= mul_acc_q;
        ST_MULB: b_q    <= mul_acc_q;
        ST_SD:   sd_q   <= div_quot[TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.sent_total     <= sent_q;
      out_q.received_total <= recv_q;
      out_q.loss_percent   <= loss_q;
      out_q.rtt_valid      <= rtt_valid;
      out_q.min_rtt_us     <= rtt_valid ? min_q : '0;
      out_q.avg_rtt_us     <= avg_q;
      out_q.max_rtt_us     <= rtt_valid ? max_q : '0;
      out_q.stddev_rtt_us  <= sd_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    sts_o           = '0;
    sts_o.is_sent   = (in_data_i.operation == OP_SENT);
    sts_o.is_reply  = (in_data_i.operation == OP_REPLY);
    sts_o.is_report = (in_data_i.operation == OP_REPORT);
    sts_o.rtt_valid = rtt_valid;
    sts_o.multi     = (recv_q > COUNT_BITS'(1));
    sts_o.div_done  = div_done;
    sts_o.mul_done  = mul_done_q;
    sts_o.sqrt_done = sqrt_done;
    sts_o.diff_neg  = diff_w[PROD_W];
    sts_o.out_free  = !out_valid_q || !out_stall_i;
  end

endmodule

>>> rtl/rtts_ctrl.sv
// Sequencer for event updates and the multi-step report computation.
module rtts_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  rtts_pkg::sts_t  sts_i,
  output rtts_pkg::cmd_t  cmd_o,
  output logic            in_stall_o
);
  import rtts_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign accept = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept && sts_i.is_report) state_d = S_LOSS;
      S_LOSS: if (sts_i.div_done) state_d = sts_i.rtt_valid ? S_AVG : S_OUT;
      S_AVG:  if (sts_i.div_done) state_d = sts_i.multi ? S_MULA : S_OUT;
      S_MULA: if (sts_i.mul_done) state_d = S_MULB;
      S_MULB: if (sts_i.mul_done) state_d = S_SUB;
      S_SUB:  state_d = sts_i.diff_neg ? S_OUT : S_SQRT;
      S_SQRT: if (sts_i.sqrt_done) state_d = S_SD;
      S_SD:   if (sts_i.div_done) state_d = S_OUT;
      S_OUT:  if (sts_i.out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.div_sel = DIV_LOSS;
    cmd_o.mul_sel = MUL_A;
    cmd_o.store   = ST_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.upd_sent  = sts_i.is_sent;
          cmd_o.upd_reply = sts_i.is_reply;
          cmd_o.clear_res = sts_i.is_report;
          cmd_o.div_start = sts_i.is_report;
        end
      end
      S_LOSS: begin
        if (sts_i.div_done) begin
          cmd_o.store     = ST_LOSS;
          cmd_o.div_start = sts_i.rtt_valid;
          cmd_o.div_sel   = DIV_AVG;
        end
      end
      S_AVG: begin
        if (sts_i.div_done) begin
          cmd_o.store     = ST_AVG;
          cmd_o.mul_start = sts_i.multi;
        end
      end
      S_MULA: begin
        if (sts_i.mul_done) begin
          cmd_o.store     = ST_MULA;
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = MUL_B;
        end
      end
      S_MULB: begin
        if (sts_i.mul_done) cmd_o.store = ST_MULB;
      end
      S_SUB: begin
        cmd_o.sqrt_start = !sts_i.diff_neg;
      end
      S_SQRT: begin
        if (sts_i.sqrt_done) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_SD;
        end
      end
      S_SD: begin
        if (sts_i.div_done) cmd_o.store = ST_SD;
      end
      S_OUT: begin
        cmd_o.out_load = sts_i.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

>>> dv/rtts_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the ping statistics block: tracks the running statistics and checks every report.
module rtts_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  rtts_pkg::in_t    in_data_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  rtts_pkg::out_t   out_data_i,
  output int               mismatches_o,
  output int               pending_o,
  output int               reports_checked_o
);
  import rtts_pkg::*;

  logic [COUNT_BITS-1:0] sent_cnt   = '0;
  logic [COUNT_BITS-1:0] rcvd_cnt   = '0;
  logic [SUM_W-1:0]      rtt_sum    = '0;
  logic [SQS_W-1:0]      rtt_sq_sum = '0;
  logic [TIME_BITS-1:0]  rtt_min    = '1;
  logic [TIME_BITS-1:0]  rtt_max    = '0;

  out_t awaited_reports[$];
  int   mismatch_cnt = 0;
  int   pending_cnt  = 0;
  int   checked_cnt  = 0;

  assign mismatches_o      = mismatch_cnt;
  assign pending_o         = pending_cnt;
  assign reports_checked_o = checked_cnt;

  // Statistics as a report would give them from the current running state.
  function automatic out_t ping_summary();
    out_t                r;
    logic [PROD_W-1:0]   scaled_sq;
    logic [PROD_W-1:0]   sum_sq;
    logic [PROD_W-1:0]   spread;
    logic [ROOT_W-1:0]   root;
    logic [ROOT_W-1:0]   trial;
    longint unsigned     loss;
    r    = '0;
    loss = 0;
    r.sent_total     = sent_cnt;
    r.received_total = rcvd_cnt;
    if (sent_cnt != 0 && rcvd_cnt < sent_cnt) begin
      loss = (64'(LOSS_SCALE) * (64'(sent_cnt) - 64'(rcvd_cnt))) / 64'(sent_cnt);
    end
    r.loss_percent = LOSS_BITS'(loss);
    if (rcvd_cnt != 0) begin
      r.rtt_valid  = 1'b1;
      r.min_rtt_us = rtt_min;
      r.max_rtt_us = rtt_max;
      r.avg_rtt_us = TIME_BITS'(rtt_sum / rcvd_cnt);
      if (rcvd_cnt > 1) begin
        // n*S2 - S1^2, then a bit-by-bit integer square root
        scaled_sq = PROD_W'(rtt_sq_sum) * PROD_W'(rcvd_cnt);
        sum_sq    = PROD_W'(rtt_sum) * PROD_W'(rtt_sum);
        if (sum_sq <= scaled_sq) begin
          spread = scaled_sq - sum_sq;
          root   = '0;
          for (int k = ROOT_W - 1; k >= 0; k--) begin
            trial = root | (ROOT_W'(1) << k);
            if (PROD_W'(trial) * PROD_W'(trial) <= spread) root = trial;
          end
          r.stddev_rtt_us = TIME_BITS'(root / rcvd_cnt);
        end
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t exp_rep;
    if (!rst_ni) begin
      sent_cnt   = '0;
      rcvd_cnt   = '0;
      rtt_sum    = '0;
      rtt_sq_sum = '0;
      rtt_min    = '1;
      rtt_max    = '0;
      awaited_reports.delete();
    end else begin
      // result side first; a report accepted now cannot already be out
      if (out_valid_i && !out_stall_i) begin
        if (awaited_reports.size() == 0) begin
          $error("report transfer with no report outstanding");
          mismatch_cnt++;
        end else begin
          exp_rep = awaited_reports.pop_front();
          check_field("sent_total", 32'(exp_rep.sent_total), 32'(out_data_i.sent_total));
          check_field("received_total", 32'(exp_rep.received_total),
                      32'(out_data_i.received_total));
          check_field("loss_percent", 32'(exp_rep.loss_percent), 32'(out_data_i.loss_percent));
          check_field("rtt_valid", 32'(exp_rep.rtt_valid), 32'(out_data_i.rtt_valid));
          check_field("min_rtt_us", 32'(exp_rep.min_rtt_us), 32'(out_data_i.min_rtt_us));
          check_field("avg_rtt_us", 32'(exp_rep.avg_rtt_us), 32'(out_data_i.avg_rtt_us));
          check_field("max_rtt_us", 32'(exp_rep.max_rtt_us), 32'(out_data_i.max_rtt_us));
          check_field("stddev_rtt_us", 32'(exp_rep.stddev_rtt_us),
                      32'(out_data_i.stddev_rtt_us));
          checked_cnt++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        case (in_data_i.operation)
          OP_SENT: begin
            if (sent_cnt != '1) sent_cnt++;
          end
          OP_REPLY: begin
            // saturated count freezes the sums but min/max keep tracking
            if (rcvd_cnt != '1) begin
              rcvd_cnt++;
              rtt_sum    += SUM_W'(in_data_i.rtt_us);
              rtt_sq_sum += SQS_W'(in_data_i.rtt_us) * SQS_W'(in_data_i.rtt_us);
            end
            if (in_data_i.rtt_us < rtt_min) rtt_min = in_data_i.rtt_us;
            if (in_data_i.rtt_us > rtt_max) rtt_max = in_data_i.rtt_us;
          end
          OP_REPORT: begin
            awaited_reports.push_back(ping_summary());
          end
          default: ;
        endcase
      end
    end
    pending_cnt = awaited_reports.size();
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// Testbench top: drives ping events into the statistics block and decides pass or fail.
module tb;
  import rtts_pkg::*;

  // Spare opcode, must be dropped by the block with no effect.
  localparam logic [OP_BITS-1:0]   OP_UNUSED    = 2'd3;
  localparam logic [TIME_BITS-1:0] TIME_MAX     = '1;
  localparam int                   RANDOM_ITEMS = 1600;
  // idle margin after the last report has been checked
  localparam int                   DRAIN_CYCLES = 400;
  // Run-length limit: the worst case if every item were a report, with stalls,
  // taken about five times over.
  localparam longint               CYCLE_LIMIT  = 2_000_000;

  logic clk       = 1'b0;
  logic rst_ni    = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     items_driven  = 0;
  longint cycles        = 0;
  int     mismatches;
  int     pending;
  int     reports_checked;

  always #5 clk = ~clk;

  round_trip_time_statistics_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  rtts_checker checker_i (
    .clk_i             (clk),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .in_data_i         (in_data),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .out_data_i        (out_data),
    .mismatches_o      (mismatches),
    .pending_o         (pending),
    .reports_checked_o (reports_checked)
  );

  // Receiver back-pressure: independent random stall, re-rolled every cycle.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("round_trip_time_statistics_core verification failed");
      $finish;
    end
  end

  // One input transfer. Entered and left at a falling edge. Random gaps drop
  // valid first; once raised, valid and payload hold until the block takes it.
  task automatic send_item(input logic [OP_BITS-1:0] op, input logic [TIME_BITS-1:0] rtt);
    in_t item;
    item.operation = op;
    item.rtt_us    = rtt;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (op != OP_UNUSED) items_driven++;
  endtask

  initial begin
    int                   random_start;
    int                   phase_end;
    int                   progress;
    int                   pick;
    logic [TIME_BITS-1:0] rtt;

    repeat (10) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    // ---- directed: empty statistics, first reply, surplus replies, spare opcode
    // Times stay mid-range so min/max are still free to move later on.
    send_item(OP_REPORT, TIME_BITS'(0));        // nothing sent, nothing received
    send_item(OP_SENT, TIME_BITS'(0));
    send_item(OP_REPORT, TIME_BITS'(0));        // all lost, no reply yet
    send_item(OP_REPLY, TIME_BITS'(510000));
    send_item(OP_REPORT, TIME_BITS'(0));        // single reply, deviation zero
    send_item(OP_SENT, TIME_BITS'(0));
    send_item(OP_SENT, TIME_BITS'(0));
    send_item(OP_SENT, TIME_BITS'(0));
    send_item(OP_REPLY, TIME_BITS'(505000));
    send_item(OP_REPORT, TIME_BITS'(0));        // two replies, partial loss
    send_item(OP_REPLY, TIME_BITS'(515000));
    send_item(OP_REPLY, TIME_BITS'(512345));
    send_item(OP_REPLY, TIME_BITS'(509999));
    send_item(OP_REPORT, TIME_BITS'(0));        // more replies than sent
    send_item(OP_UNUSED, TIME_MAX);             // must not touch the maximum
    send_item(OP_UNUSED, TIME_BITS'(0));        // must not touch the minimum
    send_item(OP_REPORT, TIME_MAX);
    send_item(OP_SENT, TIME_MAX);
    send_item(OP_REPORT, TIME_BITS'(0));

    // ---- random: ping exchanges with a time window that widens as the run
    // goes, so min and max keep moving; sprinkled with reports, stray
    // replies and the spare opcode. Three idle mixes in turn.
    random_start = items_driven;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 62 : 0;
      recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 19 : 0;
      phase_end     = items_driven + RANDOM_ITEMS / 3;
      while (items_driven < phase_end) begin
        progress = (items_driven - random_start) * 1000 / RANDOM_ITEMS;
        if (progress > 1000) progress = 1000;
        rtt  = TIME_BITS'($urandom_range(520000 + progress * 528, 500000 - progress * 500));
        pick = $urandom_range(99);
        if (pick < 70) begin
          send_item(OP_SENT, TIME_BITS'($urandom()));
          if ($urandom_range(99) < 85) send_item(OP_REPLY, rtt);
        end else if (pick < 88) begin
          send_item(OP_REPORT, TIME_BITS'($urandom()));
        end else if (pick < 95) begin
          send_item(OP_UNUSED, TIME_BITS'($urandom()));
        end else begin
          send_item(OP_REPLY, rtt);
        end
      end
    end
    send_item(OP_REPORT, TIME_BITS'(0));
    in_valid <= 1'b0;

    // ---- drain and verdict
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Drove %0d ping events (directed, three idle mixes); %0d reports compared.",
             items_driven, reports_checked);
    $display("Included empty statistics, lone reply, surplus replies and the spare opcode.");
    if (mismatches == 0) begin
      $display("round_trip_time_statistics_core verification clean");
    end else begin
      $display("round_trip_time_statistics_core verification failed");
    end
    $finish;
  end

endmodule

>>> round_trip_time_statistics_core.f
rtl/rtts_pkg.sv
rtl/rtts_div.sv
rtl/rtts_sqrt.sv
rtl/rtts_datapath.sv
rtl/rtts_ctrl.sv
rtl/round_trip_time_statistics_core.sv
dv/rtts_checker.sv
dv/tb.sv
